@@ rtl/upq_pkg.sv @@
// Shared types and codes for the unsorted priority queue core.
package upq_pkg;

	// Command codes
	localparam logic [2:0] OP_ENQ  = 3'd0;
	localparam logic [2:0] OP_DEQ  = 3'd1;
	localparam logic [2:0] OP_PEEK = 3'd2;
	localparam logic [2:0] OP_CHG  = 3'd3;
	localparam logic [2:0] OP_CLR  = 3'd4;

	// Result status codes
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_EMPTY = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;
	localparam logic [1:0] STAT_RAISE = 2'd3;

	// Command item
	typedef struct packed {
		logic [2:0]          opcode;
		logic [15:0]         item_tag;
		logic signed [31:0]  item_priority;
	} upq_cmd_t;

	// Result item
	typedef struct packed {
		logic [15:0]         out_tag;
		logic signed [31:0]  out_priority;
		logic [1:0]          status;
		logic [6:0]          entry_count;
		logic                is_empty;
	} upq_rsp_t;

	// Broadcast control from the sequencer to every cell
	typedef struct packed {
		logic enq_we;    // write the bus entry into the cell at the fill point
		logic shift_en;  // close the gap left by a dequeue
		logic chg_mode;  // wave runs a priority change rather than a minimum search
	} upq_cell_ctrl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} upq_state_t;

endpackage

@@ rtl/upq_cell.sv @@
// One queue slot: holds an entry and passes the search wave to its right-hand neighbour.
module upq_cell #(
	parameter int TAG_BITS = 16,
	parameter int CW       = 7,
	parameter int IW       = 6,
	parameter int IDX      = 0
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  upq_pkg::upq_cell_ctrl_t     ctrl,
	input  logic [CW-1:0]               count,
	input  logic [TAG_BITS-1:0]         bus_tag,
	input  logic signed [31:0]          bus_prio,
	input  logic [IW-1:0]               min_idx,
	// neighbour entry for the gap-closing shift
	input  logic [TAG_BITS-1:0]         nxt_tag,
	input  logic signed [31:0]          nxt_prio,
	output logic [TAG_BITS-1:0]         ent_tag,
	output logic signed [31:0]          ent_prio,
	// wave in from the left
	input  logic                        wi_valid,
	input  logic                        wi_have,
	input  logic                        wi_stop,
	input  logic [TAG_BITS-1:0]         wi_tag,
	input  logic signed [31:0]          wi_prio,
	input  logic [IW-1:0]               wi_idx,
	// wave out to the right
	output logic                        wo_valid,
	output logic                        wo_have,
	output logic                        wo_stop,
	output logic [TAG_BITS-1:0]         wo_tag,
	output logic signed [31:0]          wo_prio,
	output logic [IW-1:0]               wo_idx
);

	logic [TAG_BITS-1:0]  tag_q;
	logic signed [31:0]   prio_q;
	logic                 wv_q, have_q, stop_q;
	logic [TAG_BITS-1:0]  wtag_q;
	logic signed [31:0]   wprio_q;
	logic [IW-1:0]        widx_q;

	logic occ, own_less, take, match, raise;

	// Per-cell compare against the wave
	always_comb begin
		occ      = (count > CW'(IDX));
		own_less = (prio_q < wi_prio) || ((prio_q == wi_prio) && (tag_q < wi_tag));
		take     = !ctrl.chg_mode && occ && (!wi_have || own_less);
		match    = ctrl.chg_mode && occ && !wi_stop && (tag_q == bus_tag);
		raise    = match && (prio_q < bus_prio);
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (ctrl.enq_we && (count == CW'(IDX))) begin
			tag_q  <= bus_tag;
			prio_q <= bus_prio;
		end else if (ctrl.shift_en && (IW'(IDX) >= min_idx)) begin
			tag_q  <= nxt_tag;
			prio_q <= nxt_prio;
		end else if (wi_valid && match && !raise) begin
			prio_q <= bus_prio;
		end
	end

	// Wave stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wv_q <= 1'b0;
		end else begin
			wv_q <= wi_valid;
		end
	end

	// Wave stage payload
	always_ff @(posedge clk) begin
		if (wi_valid) begin
			have_q  <= wi_have || take;
			stop_q  <= wi_stop || raise;
			wtag_q  <= take ? tag_q : wi_tag;
			wprio_q <= take ? prio_q : wi_prio;
			widx_q  <= take ? IW'(IDX) : wi_idx;
		end
	end

	assign ent_tag  = tag_q;
	assign ent_prio = prio_q;
	assign wo_valid = wv_q;
	assign wo_have  = have_q;
	assign wo_stop  = stop_q;
	assign wo_tag   = wtag_q;
	assign wo_prio  = wprio_q;
	assign wo_idx   = widx_q;

endmodule

@@ rtl/unsorted_priority_queue_core.sv @@
// Min priority queue held as a row of DEPTH cells in insertion order. Enqueue, clear and unused
// codes, and dequeue or peek on an empty queue, go straight to the finish state. Other dequeues and
// peeks, and priority change, send a wave through the row one cell per cycle before they finish.
// One command is worked on at a time; a finished result may wait in the output register while the
// next command is accepted. Dequeue and peek return the first entry with the least priority, ties to
// the smaller tag; dequeue closes the gap with a single shift as the wave leaves the last cell.
module unsorted_priority_queue_core #(
	parameter int DEPTH    = 64,
	parameter int TAG_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_ready,
	input  upq_pkg::upq_cmd_t  cmd,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output upq_pkg::upq_rsp_t  rsp
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = $clog2(DEPTH);

	upq_pkg::upq_state_t      state_q, state_d;
	upq_pkg::upq_cell_ctrl_t  ctrl;

	logic [2:0]            cmd_op_q;
	logic [TAG_BITS-1:0]   cmd_tag_q;
	logic signed [31:0]    cmd_prio_q;
	logic [CW-1:0]         count_q;
	logic                  start_q;
	logic [TAG_BITS-1:0]   res_tag_q;
	logic signed [31:0]    res_prio_q;
	logic [1:0]            res_status_q;
	logic                  rsp_valid_q;
	upq_pkg::upq_rsp_t     rsp_q;

	logic                  accept, scan_go, scan_end, load_rsp;
	logic [TAG_BITS+15:0]  in_tag_ext;
	logic [TAG_BITS-1:0]   in_tag;
	logic [TAG_BITS+15:0]  out_tag_ext;
	logic [CW+6:0]         count_ext;
	logic [TAG_BITS-1:0]   bus_tag;
	logic signed [31:0]    bus_prio;

	// Wave and neighbour links along the row
	logic                  w_valid [DEPTH+1];
	logic                  w_have  [DEPTH+1];
	logic                  w_stop  [DEPTH+1];
	logic [TAG_BITS-1:0]   w_tag   [DEPTH+1];
	logic signed [31:0]    w_prio  [DEPTH+1];
	logic [IW-1:0]         w_idx   [DEPTH+1];
	logic [TAG_BITS-1:0]   e_tag   [DEPTH+1];
	logic signed [31:0]    e_prio  [DEPTH+1];

	// Tag width conversion
	assign in_tag_ext  = {TAG_BITS'(0), cmd.item_tag};
	assign in_tag      = in_tag_ext[TAG_BITS-1:0];
	assign out_tag_ext = {16'(0), res_tag_q};
	assign count_ext   = {7'(0), count_q};

	// Entry bus: the incoming item while idle, the held command otherwise
	assign bus_tag  = (state_q == upq_pkg::ST_IDLE) ? in_tag : cmd_tag_q;
	assign bus_prio = (state_q == upq_pkg::ST_IDLE) ? cmd.item_priority : cmd_prio_q;

	// Wave entry into the first cell
	assign w_valid[0] = start_q;
	assign w_have[0]  = 1'b0;
	assign w_stop[0]  = 1'b0;
	assign w_tag[0]   = '0;
	assign w_prio[0]  = '0;
	assign w_idx[0]   = '0;
	assign e_tag[DEPTH]  = '0;
	assign e_prio[DEPTH] = '0;

	assign scan_end = w_valid[DEPTH];

	// Cell row
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		upq_cell #(
			.TAG_BITS (TAG_BITS),
			.CW       (CW),
			.IW       (IW),
			.IDX      (i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.count    (count_q),
			.bus_tag  (bus_tag),
			.bus_prio (bus_prio),
			.min_idx  (w_idx[DEPTH]),
			.nxt_tag  (e_tag[i+1]),
			.nxt_prio (e_prio[i+1]),
			.ent_tag  (e_tag[i]),
			.ent_prio (e_prio[i]),
			.wi_valid (w_valid[i]),
			.wi_have  (w_have[i]),
			.wi_stop  (w_stop[i]),
			.wi_tag   (w_tag[i]),
			.wi_prio  (w_prio[i]),
			.wi_idx   (w_idx[i]),
			.wo_valid (w_valid[i+1]),
			.wo_have  (w_have[i+1]),
			.wo_stop  (w_stop[i+1]),
			.wo_tag   (w_tag[i+1]),
			.wo_prio  (w_prio[i+1]),
			.wo_idx   (w_idx[i+1])
		);
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= upq_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and cell control
	always_comb begin
		state_d       = state_q;
		cmd_ready     = 1'b0;
		scan_go       = 1'b0;
		load_rsp      = 1'b0;
		ctrl.enq_we   = 1'b0;
		ctrl.shift_en = 1'b0;
		ctrl.chg_mode = (cmd_op_q == upq_pkg::OP_CHG);
		case (state_q)
			upq_pkg::ST_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					state_d = upq_pkg::ST_FINISH;
					case (cmd.opcode)
						upq_pkg::OP_ENQ: begin
							ctrl.enq_we = (count_q != CW'(DEPTH));
						end
						upq_pkg::OP_DEQ, upq_pkg::OP_PEEK: begin
							if (count_q != '0) begin
								scan_go = 1'b1;
								state_d = upq_pkg::ST_SCAN;
							end
						end
						upq_pkg::OP_CHG: begin
							scan_go = 1'b1;
							state_d = upq_pkg::ST_SCAN;
						end
						default: begin
							state_d = upq_pkg::ST_FINISH;
						end
					endcase
				end
			end
			upq_pkg::ST_SCAN: begin
				if (scan_end) begin
					ctrl.shift_en = (cmd_op_q == upq_pkg::OP_DEQ);
					state_d       = upq_pkg::ST_FINISH;
				end
			end
			upq_pkg::ST_FINISH: begin
				if (!rsp_valid_q || rsp_ready) begin
					load_rsp = 1'b1;
					state_d  = upq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = upq_pkg::ST_IDLE;
			end
		endcase
	end

	assign accept = cmd_valid && cmd_ready;

	// Control registers: fill count, wave launch, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			start_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			start_q <= scan_go;
			if (accept && (cmd.opcode == upq_pkg::OP_ENQ) && (count_q != CW'(DEPTH))) begin
				count_q <= count_q + CW'(1);
			end else if (accept && (cmd.opcode == upq_pkg::OP_CLR)) begin
				count_q <= '0;
			end else if (ctrl.shift_en) begin
				count_q <= count_q - CW'(1);
			end
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Held command and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_op_q     <= cmd.opcode;
			cmd_tag_q    <= in_tag;
			cmd_prio_q   <= cmd.item_priority;
			res_tag_q    <= '0;
			res_prio_q   <= '0;
			res_status_q <= upq_pkg::STAT_OK;
			if ((cmd.opcode == upq_pkg::OP_ENQ) && (count_q == CW'(DEPTH))) begin
				res_status_q <= upq_pkg::STAT_FULL;
			end
			if (((cmd.opcode == upq_pkg::OP_DEQ) || (cmd.opcode == upq_pkg::OP_PEEK))
					&& (count_q == '0)) begin
				res_status_q <= upq_pkg::STAT_EMPTY;
			end
		end else if ((state_q == upq_pkg::ST_SCAN) && scan_end) begin
			if (cmd_op_q == upq_pkg::OP_CHG) begin
				if (w_stop[DEPTH]) begin
					res_status_q <= upq_pkg::STAT_RAISE;
				end
			end else begin
				res_tag_q  <= w_tag[DEPTH];
				res_prio_q <= w_prio[DEPTH];
			end
		end
		if (load_rsp) begin
			rsp_q.out_tag      <= out_tag_ext[15:0];
			rsp_q.out_priority <= res_prio_q;
			rsp_q.status       <= res_status_q;
			rsp_q.entry_count  <= count_ext[6:0];
			rsp_q.is_empty     <= (count_q == '0);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Checks
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("fill count beyond depth");

	a_no_wave_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == upq_pkg::ST_IDLE) |-> (!start_q && !scan_end))
		else $error("search wave in flight while idle");

	a_enq_count: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (cmd.opcode == upq_pkg::OP_ENQ) && (count_q != CW'(DEPTH)))
		|=> (count_q == $past(count_q) + CW'(1)))
		else $error("enqueue did not advance fill count");

	a_empty_status: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (rsp.status == upq_pkg::STAT_EMPTY)) |-> rsp.is_empty)
		else $error("empty status on a non-empty queue");

	a_scan_start: assert property (@(posedge clk) disable iff (!arst_n)
		start_q |-> (state_q == upq_pkg::ST_SCAN))
		else $error("wave launched outside a scan");

endmodule
